// ----- design/evsu_pkg.sv -----
package evsu_pkg;

    localparam int MAX_CHUNK_SAMPLES = 2048;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int THR_W    = 16;
    localparam int RUN_W    = 6;
    localparam int BYTES_W  = 19;
    localparam int SUM_W    = 27;
    localparam int CNT_W    = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int PROD_W   = THR_W + CNT_W;
    localparam int CMP_W    = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BYTES_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LEVEL           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENT_CHUNKS_TO_STOP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VAD_ENABLE            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_BYTES          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD_BYTES      = 3'd4;

    localparam logic [THR_W-1:0]   RST_QUIET_LEVEL           = 16'd800;
    localparam logic [RUN_W-1:0]   RST_SILENT_CHUNKS_TO_STOP = 6'd40;
    localparam logic               RST_VAD_ENABLE            = 1'b1;
    localparam logic [BYTES_W-1:0] RST_WARMUP_BYTES          = 19'd16000;
    localparam logic [BYTES_W-1:0] RST_MAX_RECORD_BYTES      = 19'd320000;

    typedef enum logic [1:0] {
        STOP_NONE    = 2'd0,
        STOP_SILENCE = 2'd1,
        STOP_LIMIT   = 2'd2
    } stop_reason_t;

    typedef struct packed {
        logic [THR_W-1:0]   quiet_level;
        logic [RUN_W-1:0]   silent_chunks_to_stop;
        logic               vad_enable;
        logic [BYTES_W-1:0] warmup_bytes;
        logic [BYTES_W-1:0] max_record_bytes;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       chunk_end;
        logic                       start_new;
    } in_beat_t;

    typedef struct packed {
        logic               chunk_checked;
        logic               chunk_silent;
        logic [RUN_W-1:0]   silent_run;
        stop_reason_t       stop_reason;
        logic [BYTES_W-1:0] recorded_bytes;
    } result_t;

endpackage

// ----- design/evsu_if.sv -----
interface evsu_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [evsu_pkg::SAMPLE_W-1:0]  sample;
    logic                                  chunk_end;
    logic                                  start_new;

    modport source (output valid, output sample, output chunk_end, output start_new,
                    input ready);
    modport sink (input valid, input sample, input chunk_end, input start_new,
                  output ready);
endinterface

interface evsu_out_if;
    logic                              valid;
    logic                              ready;
    logic                              chunk_checked;
    logic                              chunk_silent;
    logic [evsu_pkg::RUN_W-1:0]        silent_run;
    logic [1:0]                        stop_reason;
    logic [evsu_pkg::BYTES_W-1:0]      recorded_bytes;

    modport source (output valid, output chunk_checked, output chunk_silent,
                    output silent_run, output stop_reason, output recorded_bytes,
                    input ready);
    modport sink (input valid, input chunk_checked, input chunk_silent,
                  input silent_run, input stop_reason, input recorded_bytes,
                  output ready);
endinterface

// ----- design/energy_vad_silence_stop_unit.sv -----
// Energy-based voice activity detector that ends a recording on silence. One sample beat
// is taken every clock cycle while the result side keeps up; a sample passes an input
// register, then combinational accumulate, limit check and silence test (one 16 x 12
// multiply against the chunk sum), and a result beat is held in the output register. A
// result beat comes only for a closed chunk (chunk end, full chunk of 2048 samples, or
// byte limit); after a stop, samples are dropped until a beat with start_new.
// Configuration writes take effect on the next cycle and belong between recordings or
// while no beat is pending.
module energy_vad_silence_stop_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [evsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evsu_pkg::CFG_DATA_W-1:0]   cfg_data,
    evsu_in_if.sink                           samples,
    evsu_out_if.source                        results
);

    evsu_pkg::cfg_t     cfg;
    evsu_pkg::in_beat_t in_beat_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               advance;
    logic               res_valid;
    evsu_pkg::result_t  res;
    evsu_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    evsu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    evsu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (advance),
        .beat      (in_beat_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (samples.ready)
            in_valid_next = samples.valid;

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            in_beat_reg.sample    <= samples.sample;
            in_beat_reg.chunk_end <= samples.chunk_end;
            in_beat_reg.start_new <= samples.start_new;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    assign results.valid          = out_valid_reg;
    assign results.chunk_checked  = out_reg.chunk_checked;
    assign results.chunk_silent   = out_reg.chunk_silent;
    assign results.silent_run     = out_reg.silent_run;
    assign results.stop_reason    = out_reg.stop_reason;
    assign results.recorded_bytes = out_reg.recorded_bytes;

endmodule

// ----- design/evsu_cfg_regs.sv -----
module evsu_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [evsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evsu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output evsu_pkg::cfg_t                    cfg
);

    evsu_pkg::cfg_t cfg_reg;
    evsu_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                evsu_pkg::REG_QUIET_LEVEL:
                    cfg_next.quiet_level = cfg_data[evsu_pkg::THR_W-1:0];
                evsu_pkg::REG_SILENT_CHUNKS_TO_STOP:
                    cfg_next.silent_chunks_to_stop = cfg_data[evsu_pkg::RUN_W-1:0];
                evsu_pkg::REG_VAD_ENABLE:
                    cfg_next.vad_enable = cfg_data[0];
                evsu_pkg::REG_WARMUP_BYTES:
                    cfg_next.warmup_bytes = cfg_data[evsu_pkg::BYTES_W-1:0];
                evsu_pkg::REG_MAX_RECORD_BYTES:
                    cfg_next.max_record_bytes = cfg_data[evsu_pkg::BYTES_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quiet_level           <= evsu_pkg::RST_QUIET_LEVEL;
            cfg_reg.silent_chunks_to_stop <= evsu_pkg::RST_SILENT_CHUNKS_TO_STOP;
            cfg_reg.vad_enable            <= evsu_pkg::RST_VAD_ENABLE;
            cfg_reg.warmup_bytes          <= evsu_pkg::RST_WARMUP_BYTES;
            cfg_reg.max_record_bytes      <= evsu_pkg::RST_MAX_RECORD_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/evsu_core.sv -----
module evsu_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  evsu_pkg::cfg_t       cfg,
    input  logic                 fire,
    input  evsu_pkg::in_beat_t   beat,
    output logic                 res_valid,
    output evsu_pkg::result_t    res
);

    logic [evsu_pkg::SUM_W-1:0]   sum_reg,     sum_next;
    logic [evsu_pkg::CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [evsu_pkg::BYTES_W-1:0] pos_reg,     pos_next;
    logic [evsu_pkg::RUN_W-1:0]   run_reg,     run_next;
    logic                         stopped_reg, stopped_next;

    logic [evsu_pkg::SUM_W-1:0]   base_sum;
    logic [evsu_pkg::CNT_W-1:0]   base_cnt;
    logic [evsu_pkg::BYTES_W-1:0] base_pos;
    logic [evsu_pkg::RUN_W-1:0]   base_run;
    logic                         base_stopped;

    logic [evsu_pkg::MAG_W-1:0]   mag;
    logic [evsu_pkg::SUM_W:0]     sum_wide;
    logic [evsu_pkg::SUM_W-1:0]   sum_new;
    logic [evsu_pkg::CNT_W-1:0]   cnt_new;
    logic [evsu_pkg::BYTES_W:0]   end_raw;
    logic [evsu_pkg::BYTES_W-1:0] end_pos;
    logic                         limit_hit;
    logic                         close;
    logic                         checked;
    logic                         silent;
    logic [evsu_pkg::PROD_W-1:0]  prod;
    logic [evsu_pkg::RUN_W-1:0]   run_new;
    evsu_pkg::stop_reason_t       reason;
    logic [evsu_pkg::BYTES_W-1:0] pos_new;

    always_comb
    begin
        // start request clears the recording before this sample
        if (beat.start_new)
        begin
            base_sum     = '0;
            base_cnt     = '0;
            base_pos     = '0;
            base_run     = '0;
            base_stopped = 1'b0;
        end
        else
        begin
            base_sum     = sum_reg;
            base_cnt     = cnt_reg;
            base_pos     = pos_reg;
            base_run     = run_reg;
            base_stopped = stopped_reg;
        end

        if (beat.sample[evsu_pkg::SAMPLE_W-1])
            mag = evsu_pkg::MAG_W'(~beat.sample) + evsu_pkg::MAG_W'(1);
        else
            mag = evsu_pkg::MAG_W'(beat.sample);

        sum_wide = {1'b0, base_sum} + (evsu_pkg::SUM_W + 1)'(mag);
        if (sum_wide > (evsu_pkg::SUM_W + 1)'(evsu_pkg::SUM_MAX))
            sum_new = evsu_pkg::SUM_MAX;
        else
            sum_new = sum_wide[evsu_pkg::SUM_W-1:0];

        cnt_new = base_cnt + evsu_pkg::CNT_W'(1);

        end_raw = {1'b0, base_pos} + (evsu_pkg::BYTES_W + 1)'({cnt_new, 1'b0});
        if (base_pos >= cfg.max_record_bytes)
        begin
            limit_hit = 1'b1;
            end_pos   = base_pos;
        end
        else if (end_raw >= {1'b0, cfg.max_record_bytes})
        begin
            limit_hit = 1'b1;
            end_pos   = cfg.max_record_bytes;
        end
        else
        begin
            limit_hit = 1'b0;
            end_pos   = end_raw[evsu_pkg::BYTES_W-1:0];
        end

        close = beat.chunk_end || limit_hit
              || (cnt_new == evsu_pkg::CNT_W'(evsu_pkg::MAX_CHUNK_SAMPLES));

        checked = cfg.vad_enable && (base_pos > cfg.warmup_bytes);
        prod    = evsu_pkg::PROD_W'(cfg.quiet_level) * evsu_pkg::PROD_W'(cnt_new);
        silent  = checked && (evsu_pkg::CMP_W'(sum_new) < evsu_pkg::CMP_W'(prod));

        if (!checked)
            run_new = base_run;
        else if (!silent)
            run_new = '0;
        else if (base_run < evsu_pkg::RUN_MAX)
            run_new = base_run + evsu_pkg::RUN_W'(1);
        else
            run_new = base_run;

        // silence stop wins over the limit and drops the chunk
        if (silent && (run_new >= cfg.silent_chunks_to_stop))
            reason = evsu_pkg::STOP_SILENCE;
        else if (limit_hit)
            reason = evsu_pkg::STOP_LIMIT;
        else
            reason = evsu_pkg::STOP_NONE;

        pos_new = (reason == evsu_pkg::STOP_SILENCE) ? base_pos : end_pos;

        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        run_next     = run_reg;
        stopped_next = stopped_reg;
        if (fire)
        begin
            sum_next     = base_sum;
            cnt_next     = base_cnt;
            pos_next     = base_pos;
            run_next     = base_run;
            stopped_next = base_stopped;
            if (!base_stopped)
            begin
                if (close)
                begin
                    sum_next     = '0;
                    cnt_next     = '0;
                    pos_next     = pos_new;
                    run_next     = run_new;
                    stopped_next = (reason != evsu_pkg::STOP_NONE);
                end
                else
                begin
                    sum_next = sum_new;
                    cnt_next = cnt_new;
                end
            end
        end

        res_valid          = fire && !base_stopped && close;
        res.chunk_checked  = checked;
        res.chunk_silent   = silent;
        res.silent_run     = run_new;
        res.stop_reason    = reason;
        res.recorded_bytes = pos_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            run_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            run_reg     <= run_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ----- tb/sv/energy_vad_silence_stop_unit_tb.sv -----
`timescale 1ns / 1ps

module energy_vad_silence_stop_unit_tb;
    import evsu_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    evsu_in_if  sample_ch ();
    evsu_out_if result_ch ();

    energy_vad_silence_stop_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    always #5 clk = ~clk;

    // mirror of the recording state
    cfg_t        cur_cfg;
    int unsigned chunk_sum;
    int unsigned chunk_len;
    int unsigned rec_bytes;
    int unsigned run_len;
    bit          rec_stopped;
    int          processed_beats;
    result_t     pending_chunks[$];

    int mismatch_count;
    int idle_pct;
    int hold_off_cycles;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic void clear_recording_state();
        chunk_sum   = 0;
        chunk_len   = 0;
        rec_bytes   = 0;
        run_len     = 0;
        rec_stopped = 1'b0;
    endfunction

    function automatic void predict_chunk_close(input in_beat_t b);
        int          value;
        int unsigned mag;
        int unsigned pos;
        int unsigned end_pos;
        bit          limit_hit;
        bit          checked;
        bit          silent;
        stop_reason_t reason;
        result_t     r;
        if (b.start_new)
            clear_recording_state();
        if (rec_stopped)
            return;
        processed_beats++;
        value = int'(b.sample);
        mag = (value < 0) ? -value : value;
        chunk_sum += mag;
        if (chunk_sum > 32'(SUM_MAX))
            chunk_sum = 32'(SUM_MAX);
        chunk_len++;
        pos = rec_bytes;
        if (pos >= cur_cfg.max_record_bytes)
        begin
            end_pos   = pos;
            limit_hit = 1'b1;
        end
        else
        begin
            end_pos   = pos + 2 * chunk_len;
            limit_hit = end_pos >= cur_cfg.max_record_bytes;
            if (limit_hit)
                end_pos = 32'(cur_cfg.max_record_bytes);
        end
        if (!b.chunk_end && chunk_len < MAX_CHUNK_SAMPLES && !limit_hit)
            return;
        checked = 1'b0;
        silent  = 1'b0;
        reason  = STOP_NONE;
        if (cur_cfg.vad_enable && pos > cur_cfg.warmup_bytes)
        begin
            checked = 1'b1;
            silent  = longint'(chunk_sum) <
                      longint'(cur_cfg.quiet_level) * longint'(chunk_len);
            if (silent)
            begin
                if (run_len < RUN_MAX)
                    run_len++;
                if (run_len >= cur_cfg.silent_chunks_to_stop)
                    reason = STOP_SILENCE;
            end
            else
            begin
                run_len = 0;
            end
        end
        if (reason == STOP_NONE)
        begin
            rec_bytes = end_pos & 32'h7FFFF;
            if (limit_hit)
                reason = STOP_LIMIT;
        end
        if (reason != STOP_NONE)
            rec_stopped = 1'b1;
        chunk_sum = 0;
        chunk_len = 0;
        r.chunk_checked  = checked;
        r.chunk_silent   = silent;
        r.silent_run     = RUN_W'(run_len);
        r.stop_reason    = reason;
        r.recorded_bytes = BYTES_W'(rec_bytes);
        pending_chunks.push_back(r);
    endfunction

    task automatic check_result();
        result_t want;
        if (pending_chunks.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", 32'd1, 32'd0);
            return;
        end
        want = pending_chunks.pop_front();
        if (result_ch.chunk_checked !== want.chunk_checked)
            report_mismatch("chunk_checked", 32'(result_ch.chunk_checked),
                            32'(want.chunk_checked));
        if (result_ch.chunk_silent !== want.chunk_silent)
            report_mismatch("chunk_silent", 32'(result_ch.chunk_silent),
                            32'(want.chunk_silent));
        if (result_ch.silent_run !== want.silent_run)
            report_mismatch("silent_run", 32'(result_ch.silent_run), 32'(want.silent_run));
        if (result_ch.stop_reason !== want.stop_reason)
            report_mismatch("stop_reason", 32'(result_ch.stop_reason), 32'(want.stop_reason));
        if (result_ch.recorded_bytes !== want.recorded_bytes)
            report_mismatch("recorded_bytes", 32'(result_ch.recorded_bytes),
                            32'(want.recorded_bytes));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    // result side: long hold-off on request, otherwise random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] value,
                             input logic close_chunk, input logic restart);
        in_beat_t b;
        b.sample    = value;
        b.chunk_end = close_chunk;
        b.start_new = restart;
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample    <= value;
        sample_ch.chunk_end <= close_chunk;
        sample_ch.start_new <= restart;
        do @(posedge clk); while (!sample_ch.ready);
        predict_chunk_close(b);
    endtask

    task automatic send_chunk(input int n, input int value, input bit restart);
        for (int i = 0; i < n; i++)
            send_beat(SAMPLE_W'(value), i == n - 1, restart && i == 0);
    endtask

    task automatic wait_drain();
        sample_ch.valid <= 1'b0;
        while (pending_chunks.size() != 0)
            @(posedge clk);
        // latency of beats that close no chunk
        repeat (4) @(posedge clk);
    endtask

    function automatic cfg_t make_cfg(input int thr, input int stop_count, input bit vad,
                                      input int warm, input int max_bytes);
        cfg_t c;
        c.quiet_level           = THR_W'(thr);
        c.silent_chunks_to_stop = RUN_W'(stop_count);
        c.vad_enable            = vad;
        c.warmup_bytes          = BYTES_W'(warm);
        c.max_record_bytes      = BYTES_W'(max_bytes);
        return c;
    endfunction

    task automatic reconfigure(input cfg_t c);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_QUIET_LEVEL;
        cfg_data  <= CFG_DATA_W'(c.quiet_level);
        @(posedge clk);
        cfg_index <= REG_SILENT_CHUNKS_TO_STOP;
        cfg_data  <= CFG_DATA_W'(c.silent_chunks_to_stop);
        @(posedge clk);
        cfg_index <= REG_VAD_ENABLE;
        cfg_data  <= CFG_DATA_W'(c.vad_enable);
        @(posedge clk);
        cfg_index <= REG_WARMUP_BYTES;
        cfg_data  <= CFG_DATA_W'(c.warmup_bytes);
        @(posedge clk);
        cfg_index <= REG_MAX_RECORD_BYTES;
        cfg_data  <= CFG_DATA_W'(c.max_record_bytes);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic test_reset_defaults();
        send_beat(SAMPLE_W'(-32768), 1'b0, 1'b1);
        send_beat(SAMPLE_W'(32767), 1'b0, 1'b0);
        send_beat(SAMPLE_W'(-1), 1'b1, 1'b0);
        send_beat(SAMPLE_W'(0), 1'b1, 1'b0);
    endtask

    task automatic test_silence_run();
        reconfigure(make_cfg(100, 3, 1'b1, 0, 524287));
        send_chunk(2, 5000, 1'b1);
        send_chunk(2, 99, 1'b0);
        // sum equal to threshold times count is loud
        send_chunk(2, 100, 1'b0);
        send_chunk(1, -99, 1'b0);
        send_chunk(1, 99, 1'b0);
        send_chunk(3, 0, 1'b0);
        // ignored after the stop
        send_chunk(1, 123, 1'b0);
        send_chunk(2, -5, 1'b0);
        send_chunk(1, 7, 1'b1);
    endtask

    task automatic test_stop_count_zero();
        reconfigure(make_cfg(100, 0, 1'b1, 0, 524287));
        send_chunk(1, 3000, 1'b1);
        send_chunk(1, 0, 1'b0);
        send_chunk(1, 0, 1'b0);
    endtask

    task automatic test_threshold_extremes();
        reconfigure(make_cfg(0, 2, 1'b1, 0, 524287));
        send_chunk(1, 0, 1'b1);
        send_chunk(1, 0, 1'b0);
        reconfigure(make_cfg(32768, 2, 1'b1, 0, 524287));
        send_chunk(1, -32768, 1'b0);
        send_chunk(1, 32767, 1'b0);
        send_chunk(2, -32767, 1'b0);
    endtask

    task automatic test_vad_and_warmup();
        reconfigure(make_cfg(32768, 1, 1'b0, 0, 524287));
        send_chunk(1, 0, 1'b1);
        send_chunk(3, 0, 1'b0);
        reconfigure(make_cfg(32768, 1, 1'b1, 8, 524287));
        send_chunk(2, 0, 1'b1);
        send_chunk(2, 0, 1'b0);
        send_chunk(2, 0, 1'b0);
        send_chunk(1, 0, 1'b0);
        reconfigure(make_cfg(32768, 1, 1'b1, 524287, 524287));
        send_chunk(2, 0, 1'b1);
        send_chunk(2, 0, 1'b0);
    endtask

    task automatic test_run_saturation();
        reconfigure(make_cfg(32768, 63, 1'b1, 0, 524287));
        send_chunk(1, 0, 1'b1);
        repeat (63) send_chunk(1, 1, 1'b0);
        send_chunk(1, 1, 1'b0);
    endtask

    task automatic test_byte_limit();
        // odd limit drops the last byte
        reconfigure(make_cfg(0, 1, 1'b1, 0, 41));
        send_chunk(4, 100, 1'b1);
        repeat (4) send_chunk(4, -100, 1'b0);
        send_beat(SAMPLE_W'(5), 1'b0, 1'b0);
        send_beat(SAMPLE_W'(6), 1'b1, 1'b0);
        reconfigure(make_cfg(0, 1, 1'b1, 0, 2));
        send_beat(SAMPLE_W'(1), 1'b0, 1'b1);
        send_beat(SAMPLE_W'(1), 1'b0, 1'b0);
    endtask

    task automatic test_limit_lowered();
        reconfigure(make_cfg(0, 1, 1'b1, 0, 524287));
        send_chunk(5, 9, 1'b1);
        reconfigure(make_cfg(0, 1, 1'b1, 0, 6));
        send_beat(SAMPLE_W'(9), 1'b0, 1'b0);
        reconfigure(make_cfg(32768, 1, 1'b1, 0, 524287));
        send_chunk(3, 9, 1'b1);
        reconfigure(make_cfg(32768, 1, 1'b1, 0, 4));
        send_beat(SAMPLE_W'(0), 1'b0, 1'b0);
    endtask

    task automatic test_silence_at_limit();
        reconfigure(make_cfg(32768, 1, 1'b1, 0, 8));
        send_chunk(2, -32768, 1'b1);
        send_beat(SAMPLE_W'(0), 1'b0, 1'b0);
        send_beat(SAMPLE_W'(0), 1'b0, 1'b0);
    endtask

    task automatic test_full_chunk();
        reconfigure(make_cfg(100, 2, 1'b1, 0, 524287));
        send_chunk(1, 0, 1'b1);
        repeat (MAX_CHUNK_SAMPLES) send_beat(SAMPLE_W'(-32768), 1'b0, 1'b0);
        send_chunk(1, 0, 1'b0);
    endtask

    task automatic test_backpressure();
        reconfigure(make_cfg(800, 40, 1'b0, 16000, 524287));
        idle_pct = 0;
        hold_off_cycles = 300;
        send_beat(SAMPLE_W'($urandom), 1'b1, 1'b1);
        repeat (39) send_beat(SAMPLE_W'($urandom), 1'b1, 1'b0);
        // sender holds until every result is back
        wait_drain();
        idle_pct = 10;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample(input int thr);
        int mag;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return SAMPLE_W'($urandom);
        if (pick == 3)
        begin
            case ($urandom_range(0, 3))
                0: mag = 0;
                1: mag = 1;
                2: mag = 32767;
                default: mag = 32768;
            endcase
        end
        else if (pick < 8)
        begin
            mag = $urandom_range(0, thr);
        end
        else
        begin
            mag = thr + $urandom_range(0, 4) - 2;
            if (mag < 0)
                mag = 0;
            if (mag > 32768)
                mag = 32768;
        end
        if (mag == 32768)
            return SAMPLE_W'(-32768);
        return SAMPLE_W'(($urandom_range(0, 1) != 0) ? -mag : mag);
    endfunction

    function automatic cfg_t random_setting();
        int thr;
        int stop_count;
        int warm;
        int max_bytes;
        case ($urandom_range(0, 3))
            0: thr = 0;
            1: thr = 32768;
            2: thr = $urandom_range(0, 32768);
            default: thr = $urandom_range(20, 3000);
        endcase
        case ($urandom_range(0, 9))
            0: stop_count = 0;
            1: stop_count = 63;
            default: stop_count = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 7))
            0: warm = 0;
            1: warm = 524287;
            default: warm = $urandom_range(0, 80);
        endcase
        case ($urandom_range(0, 7))
            0: max_bytes = 2;
            1: max_bytes = 524287;
            default: max_bytes = $urandom_range(2, 400);
        endcase
        return make_cfg(thr, stop_count, $urandom_range(0, 3) != 0, warm, max_bytes);
    endfunction

    task automatic random_phase(input int target, input int pct);
        cfg_t c;
        int   first;
        int   len;
        bit   restart;
        c = random_setting();
        reconfigure(c);
        idle_pct = pct;
        first = processed_beats;
        while (processed_beats - first < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                restart = (rec_stopped && k == 0 && $urandom_range(0, 3) != 0) ||
                          ($urandom_range(0, 49) == 0);
                send_beat(random_sample(c.quiet_level),
                          (k == len - 1) || ($urandom_range(0, 29) == 0), restart);
            end
        end
    endtask

    task automatic test_random();
        random_phase(130, 15);
        random_phase(130, 0);
        random_phase(130, 30);
        random_phase(130, 8);
        // last stretch runs without idling
        random_phase(130, 0);
    endtask

    initial
    begin
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample    = '0;
        sample_ch.chunk_end = 1'b0;
        sample_ch.start_new = 1'b0;
        rst_n               = 1'b0;
        mismatch_count      = 0;
        processed_beats     = 0;
        hold_off_cycles     = 0;
        idle_pct            = 10;
        cur_cfg = make_cfg(RST_QUIET_LEVEL, RST_SILENT_CHUNKS_TO_STOP, RST_VAD_ENABLE,
                           RST_WARMUP_BYTES, RST_MAX_RECORD_BYTES);
        clear_recording_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_silence_run();
        test_stop_count_zero();
        test_threshold_extremes();
        test_vad_and_warmup();
        test_run_saturation();
        test_byte_limit();
        test_limit_lowered();
        test_silence_at_limit();
        test_full_chunk();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
